// ----- src/hpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Handle pool allocator package
// Shared sizes, transaction codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package hpa_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LVL_W      = 5;
    localparam int HANDLE_W   = 4;

    typedef enum logic [1:0] {
        KIND_INIT    = 2'd0,
        KIND_SINGLE  = 2'd1,
        KIND_BATCH   = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_GRANTED      = 3'd0,
        ST_EXHAUSTED    = 3'd1,
        ST_INSUFFICIENT = 3'd2,
        ST_RELEASED     = 3'd3,
        ST_NOT_IN_USE   = 3'd4,
        ST_INIT_DONE    = 3'd5,
        ST_EMPTY_BATCH  = 3'd6
    } t_status;

    localparam logic [LVL_W-1:0] POOL_SIZE_RESET = LVL_W'(POOL_DEPTH);

    typedef struct packed {
        logic    load;
        logic    init;
        logic    grant;
        logic    reclaim;
        logic    release_hit;
        logic    idx_inc;
        logic    emit;
        t_status status;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic top_zero;
        logic iuc_zero;
        logic cnt_zero;
        logic cnt_gt_top;
        logic cnt_one;
        logic idx_end;
        logic match;
    } t_dp_sts;

endpackage

// ----- src/hpa_req_if.sv -----
// ----------------------------------------------------------------------------
// Handle pool request channel
// Valid/ready channel carrying one allocator command per transaction.
// ----------------------------------------------------------------------------
interface hpa_req_if;
    import hpa_pkg::*;

    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [LVL_W-1:0]    count;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output kind, output count, output handle, input ready);
    modport sink   (input valid, input kind, input count, input handle, output ready);
endinterface

// ----- src/hpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Handle pool response channel
// Valid/ready channel carrying one allocator result per transaction.
// ----------------------------------------------------------------------------
interface hpa_rsp_if;
    import hpa_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [HANDLE_W-1:0] granted_handle;
    logic [HANDLE_W-1:0] freed_handle;
    logic                freed_valid;
    logic [LVL_W-1:0]    free_count;
    logic                last;

    modport source (output valid, output status, output granted_handle, output freed_handle,
                    output freed_valid, output free_count, output last, input ready);
    modport sink   (input valid, input status, input granted_handle, input freed_handle,
                    input freed_valid, input free_count, input last, output ready);
endinterface

// ----- src/handle_pool_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Handle pool allocator
// Free stack and grant-ordered in-use list of numbered handles.
// ----------------------------------------------------------------------------
// One command is handled at a time. Init and single requests load their result
// register from their own state once the output register is free; a batch is
// checked against the free stack, then grants one handle per cycle while the
// output register is free, flagging the last grant; a release scans the in-use
// list one entry per cycle and loads its result on a match or at the list end.
// A new command is accepted in the cycle after the previous one wrote its final
// result, while that result may still wait in the output register. Output
// back-pressure stalls the sequencer. No clearing pass is needed after reset.
module handle_pool_allocator_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hpa_pkg::LVL_W-1:0] i_cfg_wdata,
    hpa_req_if.sink                   i_req,
    hpa_rsp_if.source                 o_rsp
);
    import hpa_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    req_ready;

    assign i_req.ready = req_ready;

    hpa_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_kind  (i_req.kind),
        .o_req_ready (req_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    hpa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_count     (i_req.count),
        .i_handle    (i_req.handle),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // A pending result seen while a new command can be taken is always final.
    a_ready_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_ready && o_rsp.valid) |-> o_rsp.last)
        else $error("new command accepted before the final result");

    // The sequencer never accepts commands back to back.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && req_ready) |=> !req_ready)
        else $error("command accepted on back-to-back cycles");

    a_free_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.free_count <= LVL_W'(POOL_DEPTH)))
        else $error("free count above pool depth");

    a_freed_only_on_exhaust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.freed_valid) |-> (o_rsp.status == ST_EXHAUSTED))
        else $error("reclaimed handle reported outside exhaustion");
`endif

endmodule

// ----- src/hpa_datapath.sv -----
// ----------------------------------------------------------------------------
// Handle pool datapath
// Free stack, in-use list, search index, batch counter and result register.
// ----------------------------------------------------------------------------
module hpa_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hpa_pkg::LVL_W-1:0]    i_cfg_wdata,
    input  logic [hpa_pkg::LVL_W-1:0]    i_count,
    input  logic [hpa_pkg::HANDLE_W-1:0] i_handle,
    input  hpa_pkg::t_dp_cmd             i_cmd,
    output hpa_pkg::t_dp_sts             o_sts,
    hpa_rsp_if.source                    o_rsp
);
    import hpa_pkg::*;

    logic [LVL_W-1:0]    r_pool_size;
    logic [HANDLE_W-1:0] r_free_stack [POOL_DEPTH];
    logic [HANDLE_W-1:0] n_free_stack [POOL_DEPTH];
    logic [LVL_W-1:0]    r_free_top, n_free_top;
    logic [HANDLE_W-1:0] r_in_use [POOL_DEPTH];
    logic [HANDLE_W-1:0] n_in_use [POOL_DEPTH];
    logic [LVL_W-1:0]    r_in_use_cnt, n_in_use_cnt;
    logic [LVL_W-1:0]    r_count, n_count;
    logic [HANDLE_W-1:0] r_handle;
    logic [LVL_W-1:0]    r_idx, n_idx;

    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_granted, n_granted;
    logic [HANDLE_W-1:0] r_freed, n_freed;
    logic                r_freed_valid, n_freed_valid;
    logic [LVL_W-1:0]    r_free_count, n_free_count;
    logic                r_last, n_last;

    logic [LVL_W-1:0]    top_m1;
    logic [HANDLE_W-1:0] pop_h;
    logic [HANDLE_W-1:0] push_h;
    logic [LVL_W-1:0]    rm_pos;
    logic [LVL_W-1:0]    init_lim;
    logic                idx_end;

    assign top_m1   = r_free_top - LVL_W'(1);
    assign pop_h    = r_free_stack[top_m1[IDX_W-1:0]];
    assign push_h   = i_cmd.reclaim ? r_in_use[0] : r_handle;
    assign rm_pos   = i_cmd.reclaim ? '0 : r_idx;
    assign init_lim = (r_pool_size > LVL_W'(POOL_DEPTH)) ? LVL_W'(POOL_DEPTH) : r_pool_size;
    assign idx_end  = (r_idx >= r_in_use_cnt);

    always_comb begin
        o_sts.out_free   = !r_out_valid || o_rsp.ready;
        o_sts.top_zero   = (r_free_top == '0);
        o_sts.iuc_zero   = (r_in_use_cnt == '0);
        o_sts.cnt_zero   = (r_count == '0);
        o_sts.cnt_gt_top = (r_count > r_free_top);
        o_sts.cnt_one    = (r_count == LVL_W'(1));
        o_sts.idx_end    = idx_end;
        o_sts.match      = !idx_end && (r_in_use[r_idx[IDX_W-1:0]] == r_handle);
    end

    always_comb begin
        n_free_stack = r_free_stack;
        n_free_top   = r_free_top;
        n_in_use     = r_in_use;
        n_in_use_cnt = r_in_use_cnt;
        n_count      = r_count;
        n_idx        = r_idx;

        if (i_cmd.load) begin
            n_count = i_count;
            n_idx   = '0;
        end
        if (i_cmd.idx_inc) begin
            n_idx = r_idx + LVL_W'(1);
        end

        if (i_cmd.init) begin
            for (int j = 0; j < POOL_DEPTH; j++) begin
                if (LVL_W'(j) < init_lim) begin
                    n_free_stack[IDX_W'(j)] = HANDLE_W'(j);
                end
            end
            n_free_top   = init_lim;
            n_in_use_cnt = '0;
        end else if (i_cmd.grant) begin
            n_free_top = top_m1;
            n_count    = r_count - LVL_W'(1);
            if (r_in_use_cnt < LVL_W'(POOL_DEPTH)) begin
                n_in_use[r_in_use_cnt[IDX_W-1:0]] = pop_h;
                n_in_use_cnt = r_in_use_cnt + LVL_W'(1);
            end
        end else if (i_cmd.reclaim || i_cmd.release_hit) begin
            // Close the gap left by the removed entry; list order is grant order.
            for (int j = 0; j < POOL_DEPTH - 1; j++) begin
                if (LVL_W'(j) >= rm_pos) begin
                    n_in_use[IDX_W'(j)] = r_in_use[IDX_W'(j + 1)];
                end
            end
            n_in_use_cnt = r_in_use_cnt - LVL_W'(1);
            if (r_free_top < LVL_W'(POOL_DEPTH)) begin
                n_free_stack[r_free_top[IDX_W-1:0]] = push_h;
                n_free_top = r_free_top + LVL_W'(1);
            end
        end
    end

    always_comb begin
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_status      = r_status;
        n_granted     = r_granted;
        n_freed       = r_freed;
        n_freed_valid = r_freed_valid;
        n_free_count  = r_free_count;
        n_last        = r_last;
        if (i_cmd.emit) begin
            n_out_valid   = 1'b1;
            n_status      = i_cmd.status;
            n_granted     = i_cmd.grant ? pop_h : '0;
            n_freed       = i_cmd.reclaim ? r_in_use[0] : '0;
            n_freed_valid = i_cmd.reclaim;
            n_free_count  = n_free_top;
            n_last        = i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size  <= POOL_SIZE_RESET;
            r_free_top   <= '0;
            r_in_use_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool_size <= i_cfg_wdata;
            end
            r_free_top   <= n_free_top;
            r_in_use_cnt <= n_in_use_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_stack  <= n_free_stack;
        r_in_use      <= n_in_use;
        r_count       <= n_count;
        r_idx         <= n_idx;
        r_status      <= n_status;
        r_granted     <= n_granted;
        r_freed       <= n_freed;
        r_freed_valid <= n_freed_valid;
        r_free_count  <= n_free_count;
        r_last        <= n_last;
        if (i_cmd.load) begin
            r_handle <= i_handle;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.granted_handle = r_granted;
    assign o_rsp.freed_handle   = r_freed;
    assign o_rsp.freed_valid    = r_freed_valid;
    assign o_rsp.free_count     = r_free_count;
    assign o_rsp.last           = r_last;

endmodule

// ----- src/hpa_controller.sv -----
// ----------------------------------------------------------------------------
// Handle pool controller
// Sequences one command at a time and drives the datapath operations.
// ----------------------------------------------------------------------------
module hpa_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  hpa_pkg::t_kind   i_req_kind,
    output logic             o_req_ready,
    input  hpa_pkg::t_dp_sts i_sts,
    output hpa_pkg::t_dp_cmd o_cmd
);
    import hpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SINGLE,
        S_BATCH_CHECK,
        S_BATCH_GRANT,
        S_SEARCH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.status = ST_GRANTED;

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_req_kind)
                        KIND_INIT:   n_state = S_INIT;
                        KIND_SINGLE: n_state = S_SINGLE;
                        KIND_BATCH:  n_state = S_BATCH_CHECK;
                        default:     n_state = S_SEARCH;
                    endcase
                end
            end
            S_INIT: begin
                if (i_sts.out_free) begin
                    o_cmd.init   = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_INIT_DONE;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    if (!i_sts.top_zero) begin
                        o_cmd.grant  = 1'b1;
                        o_cmd.status = ST_GRANTED;
                    end else begin
                        // Out of handles: reclaim the oldest grant, if any.
                        o_cmd.reclaim = !i_sts.iuc_zero;
                        o_cmd.status  = ST_EXHAUSTED;
                    end
                    n_state = S_IDLE;
                end
            end
            S_BATCH_CHECK: begin
                if (i_sts.cnt_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_EMPTY_BATCH;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.cnt_gt_top) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_INSUFFICIENT;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_BATCH_GRANT;
                end
            end
            S_BATCH_GRANT: begin
                if (i_sts.out_free) begin
                    o_cmd.grant  = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_GRANTED;
                    o_cmd.last   = i_sts.cnt_one;
                    if (i_sts.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SEARCH: begin
                if (i_sts.idx_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_NOT_IN_USE;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.match) begin
                    if (i_sts.out_free) begin
                        o_cmd.release_hit = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.status      = ST_RELEASED;
                        o_cmd.last        = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- test/handle_pool_allocator_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Handle pool allocator checker
// Watches the command and result channels, tracks the free stack and the
// in-use list, and compares every result against the predicted one.
// ----------------------------------------------------------------------------
module handle_pool_allocator_unit_checker
    import hpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LVL_W-1:0]    i_cfg_wdata,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  t_kind               i_req_kind,
    input  logic [LVL_W-1:0]    i_req_count,
    input  logic [HANDLE_W-1:0] i_req_handle,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  t_status             i_rsp_status,
    input  logic [HANDLE_W-1:0] i_rsp_granted_handle,
    input  logic [HANDLE_W-1:0] i_rsp_freed_handle,
    input  logic                i_rsp_freed_valid,
    input  logic [LVL_W-1:0]    i_rsp_free_count,
    input  logic                i_rsp_last,
    output int                  o_fault_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] granted;
        logic [HANDLE_W-1:0] freed;
        logic                freed_valid;
        logic [LVL_W-1:0]    free_count;
        logic                last;
    } t_alloc_result;

    logic [LVL_W-1:0]    pool_size;
    logic [HANDLE_W-1:0] free_stack [POOL_DEPTH];
    logic [HANDLE_W-1:0] in_use_list [POOL_DEPTH];
    int unsigned         free_top;
    int unsigned         in_use_count;
    t_alloc_result       due_results [$];
    int                  fault_count = 0;

    task automatic report_mismatch(input string what);
        fault_count++;
        $display("[%0t] allocator mismatch: %s", $realtime, what);
    endtask

    task automatic queue_result(input t_status status, input logic [HANDLE_W-1:0] granted,
                                input logic [HANDLE_W-1:0] freed, input logic freed_valid,
                                input logic last);
        t_alloc_result r;
        r.status      = status;
        r.granted     = granted;
        r.freed       = freed;
        r.freed_valid = freed_valid;
        r.free_count  = LVL_W'(free_top);
        r.last        = last;
        due_results.insert(due_results.size(), r);
    endtask

    task automatic push_free(input logic [HANDLE_W-1:0] h);
        if (free_top < POOL_DEPTH) begin
            free_stack[IDX_W'(free_top)] = h;
            free_top++;
        end
    endtask

    // Removing an entry keeps the list in grant order, oldest first.
    task automatic drop_in_use(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < in_use_count; i++)
            in_use_list[IDX_W'(i)] = in_use_list[IDX_W'(i + 1)];
        in_use_count--;
    endtask

    task automatic take_free(output logic [HANDLE_W-1:0] h);
        free_top--;
        h = free_stack[IDX_W'(free_top)];
        if (in_use_count < POOL_DEPTH) begin
            in_use_list[IDX_W'(in_use_count)] = h;
            in_use_count++;
        end
    endtask

    task automatic serve_command(input t_kind kind, input logic [LVL_W-1:0] count,
                                 input logic [HANDLE_W-1:0] handle);
        int unsigned         n;
        logic [HANDLE_W-1:0] h;
        bit                  hit;
        hit = 1'b0;
        case (kind)
            KIND_INIT: begin
                n = (pool_size > POOL_DEPTH) ? POOL_DEPTH : pool_size;
                for (int unsigned i = 0; i < n; i++)
                    free_stack[IDX_W'(i)] = HANDLE_W'(i);
                free_top     = n;
                in_use_count = 0;
                queue_result(ST_INIT_DONE, '0, '0, 1'b0, 1'b1);
            end
            KIND_SINGLE: begin
                if (free_top > 0) begin
                    take_free(h);
                    queue_result(ST_GRANTED, h, '0, 1'b0, 1'b1);
                end else if (in_use_count > 0) begin
                    // Out of handles: the oldest grant is reclaimed and the request refused.
                    h = in_use_list[0];
                    drop_in_use(0);
                    push_free(h);
                    queue_result(ST_EXHAUSTED, '0, h, 1'b1, 1'b1);
                end else begin
                    queue_result(ST_EXHAUSTED, '0, '0, 1'b0, 1'b1);
                end
            end
            KIND_BATCH: begin
                if (count == 0) begin
                    queue_result(ST_EMPTY_BATCH, '0, '0, 1'b0, 1'b1);
                end else if (count > free_top) begin
                    queue_result(ST_INSUFFICIENT, '0, '0, 1'b0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < count; i++) begin
                        take_free(h);
                        queue_result(ST_GRANTED, h, '0, 1'b0, i + 1 == count);
                    end
                end
            end
            default: begin
                for (int unsigned i = 0; i < in_use_count && !hit; i++) begin
                    if (in_use_list[IDX_W'(i)] == handle) begin
                        hit = 1'b1;
                        drop_in_use(i);
                        push_free(handle);
                    end
                end
                queue_result(hit ? ST_RELEASED : ST_NOT_IN_USE, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic check_result();
        t_alloc_result want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("result status %0d arrived with nothing pending",
                                      i_rsp_status));
            return;
        end
        want = due_results.pop_front();
        if (i_rsp_status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", i_rsp_status, want.status));
        if (i_rsp_granted_handle !== want.granted)
            report_mismatch($sformatf("granted_handle %0d, predicted %0d",
                                      i_rsp_granted_handle, want.granted));
        if (i_rsp_freed_handle !== want.freed)
            report_mismatch($sformatf("freed_handle %0d, predicted %0d",
                                      i_rsp_freed_handle, want.freed));
        if (i_rsp_freed_valid !== want.freed_valid)
            report_mismatch($sformatf("freed_valid %0b, predicted %0b",
                                      i_rsp_freed_valid, want.freed_valid));
        if (i_rsp_free_count !== want.free_count)
            report_mismatch($sformatf("free_count %0d, predicted %0d",
                                      i_rsp_free_count, want.free_count));
        if (i_rsp_last !== want.last)
            report_mismatch($sformatf("last %0b, predicted %0b", i_rsp_last, want.last));
    endtask

    // A result is checked before a command in the same cycle: a new command is
    // only taken once the previous one has produced its final result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pool_size    = POOL_SIZE_RESET;
            free_top     = 0;
            in_use_count = 0;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                free_stack[IDX_W'(i)]  = '0;
                in_use_list[IDX_W'(i)] = '0;
            end
            due_results.delete();
        end else begin
            if (i_cfg_we)
                pool_size = i_cfg_wdata;
            if (i_rsp_valid && i_rsp_ready)
                check_result();
            if (i_req_valid && i_req_ready)
                serve_command(i_req_kind, i_req_count, i_req_handle);
        end
        o_pending     = due_results.size();
        o_fault_count = fault_count;
    end

endmodule

// ----- test/handle_pool_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Handle pool allocator testbench
// Drives directed and random allocator commands under random back-pressure on
// both channels, across several pool sizes, and reports the verdict.
// ----------------------------------------------------------------------------
module handle_pool_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hpa_pkg::*;

    localparam int RUN_LIMIT = 1_000_000;
    localparam int LONG_HOLD = 400;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 45;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    logic [LVL_W-1:0] cfg_wdata;
    int               fault_count;
    int               pending;
    int               cycle_count = 0;
    bit               jitter_on = 1'b1;
    bit               hold_pending = 1'b0;
    logic [LVL_W-1:0] size_now = POOL_SIZE_RESET;

    hpa_req_if req_if ();
    hpa_rsp_if rsp_if ();

    always #2 clk = ~clk;

    handle_pool_allocator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    handle_pool_allocator_unit_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_wdata          (cfg_wdata),
        .i_req_valid          (req_if.valid),
        .i_req_ready          (req_if.ready),
        .i_req_kind           (req_if.kind),
        .i_req_count          (req_if.count),
        .i_req_handle         (req_if.handle),
        .i_rsp_valid          (rsp_if.valid),
        .i_rsp_ready          (rsp_if.ready),
        .i_rsp_status         (rsp_if.status),
        .i_rsp_granted_handle (rsp_if.granted_handle),
        .i_rsp_freed_handle   (rsp_if.freed_handle),
        .i_rsp_freed_valid    (rsp_if.freed_valid),
        .i_rsp_free_count     (rsp_if.free_count),
        .i_rsp_last           (rsp_if.last),
        .o_fault_count        (fault_count),
        .o_pending            (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("handle_pool_allocator_unit regression: fail");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request so
    // that the allocator backs up and stops taking commands.
    initial begin : rsp_stall
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready = 1'b0;
            end else if (hold_pending && !hold_done) begin
                hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                rsp_if.ready = 1'b0;
            end else if (jitter_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 16);
                rsp_if.ready = 1'b0;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue(input t_kind kind, input logic [LVL_W-1:0] count,
                         input logic [HANDLE_W-1:0] handle);
        if (jitter_on && $urandom_range(0, 5) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req_if.valid  = 1'b1;
        req_if.kind   = kind;
        req_if.count  = count;
        req_if.handle = handle;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_pool_size(input logic [LVL_W-1:0] value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we   = 1'b0;
        size_now = value;
    endtask

    task automatic random_command();
        int                  pick;
        int                  top_handle;
        logic [LVL_W-1:0]    count;
        logic [HANDLE_W-1:0] handle;
        pick = $urandom_range(0, 99);
        if (size_now == 0)
            top_handle = 0;
        else if (size_now > POOL_DEPTH)
            top_handle = POOL_DEPTH - 1;
        else
            top_handle = size_now - 1;
        // Mostly small batches so grants and releases keep the pool moving.
        count = ($urandom_range(0, 99) < 85) ? LVL_W'($urandom_range(0, 5))
                                             : LVL_W'($urandom_range(0, 31));
        handle = ($urandom_range(0, 99) < 75) ? HANDLE_W'($urandom_range(0, top_handle))
                                              : HANDLE_W'($urandom_range(0, 15));
        if (pick < 4)
            issue(KIND_INIT, count, handle);
        else if (pick < 36)
            issue(KIND_SINGLE, count, handle);
        else if (pick < 62)
            issue(KIND_BATCH, count, handle);
        else
            issue(KIND_RELEASE, count, handle);
    endtask

    initial begin
        logic [LVL_W-1:0] phase_size;
        req_if.valid  = 1'b0;
        req_if.kind   = KIND_INIT;
        req_if.count  = '0;
        req_if.handle = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Before any init nothing is free.
        issue(KIND_SINGLE, 5'd0, 4'd0);
        issue(KIND_BATCH, 5'd3, 4'd0);
        issue(KIND_BATCH, 5'd0, 4'd0);
        issue(KIND_RELEASE, 5'd0, 4'd5);
        issue(KIND_INIT, 5'd0, 4'd0);
        hold_pending = 1'b1;
        issue(KIND_BATCH, 5'd16, 4'd0);
        issue(KIND_SINGLE, 5'd31, 4'd15);
        issue(KIND_SINGLE, 5'd0, 4'd0);
        issue(KIND_RELEASE, 5'd0, 4'd15);
        issue(KIND_RELEASE, 5'd0, 4'd15);
        issue(KIND_RELEASE, 5'd0, 4'd0);
        issue(KIND_BATCH, 5'd17, 4'd0);
        issue(KIND_BATCH, 5'd31, 4'd0);
        issue(KIND_BATCH, 5'd1, 4'd0);
        issue(KIND_RELEASE, 5'd0, 4'd14);
        set_pool_size(5'd31);
        issue(KIND_INIT, 5'd0, 4'd0);
        issue(KIND_BATCH, 5'd16, 4'd0);
        issue(KIND_BATCH, 5'd1, 4'd0);
        set_pool_size(5'd0);
        issue(KIND_INIT, 5'd0, 4'd0);
        issue(KIND_SINGLE, 5'd0, 4'd0);
        issue(KIND_RELEASE, 5'd0, 4'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       phase_size = 5'd16;
                1:       phase_size = 5'd1;
                2:       phase_size = 5'd0;
                3:       phase_size = 5'd31;
                4:       phase_size = 5'd7;
                5:       phase_size = 5'd17;
                6:       phase_size = 5'd3;
                default: phase_size = LVL_W'($urandom_range(2, 15));
            endcase
            // One stretch in the middle and the whole last phase run without idling.
            jitter_on = (phase != 4) && (phase != PHASES - 1);
            set_pool_size(phase_size);
            issue(KIND_INIT, LVL_W'($urandom_range(0, 31)), HANDLE_W'($urandom_range(0, 15)));
            for (int n = 0; n < PHASE_LEN; n++)
                random_command();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fault_count == 0 && pending == 0)
            $display("handle_pool_allocator_unit regression: pass");
        else
            $display("handle_pool_allocator_unit regression: fail");
        $finish;
    end

endmodule
